@@ sv/dra_pkg.sv @@
// shared types and constants for the dns reply address extractor
package dra_pkg;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       final_byte;
  } reply_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] address_upper;
    logic [63:0] address_lower;
    logic        run_end;
  } result_item_t;

  // one classified request handed from the parser to the output side
  typedef struct packed {
    logic        has_addr;
    logic        addr_v6;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic        has_end;
    logic        end_err;
  } dra_event_t;

  localparam logic [1:0] KIND_IPV4    = 2'd0;
  localparam logic [1:0] KIND_IPV6    = 2'd1;
  localparam logic [1:0] KIND_END_OK  = 2'd2;
  localparam logic [1:0] KIND_END_ERR = 2'd3;

  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [15:0] CLASS_IN  = 16'd1;

  // address kind of an answer once its fixed part is in
  localparam logic [1:0] REC_NONE = 2'd0;
  localparam logic [1:0] REC_V4   = 2'd1;
  localparam logic [1:0] REC_V6   = 2'd2;

endpackage

@@ sv/dra_front.sv @@
// byte parser: walks header, questions and answers and classifies each request
module dra_front
  import dra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  reply_item_t reply,
  output logic        push,
  output dra_event_t  evt
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_QLABEL = 3'd1;
  localparam logic [2:0] PH_QTAIL  = 3'd2;
  localparam logic [2:0] PH_AHDR   = 3'd3;
  localparam logic [2:0] PH_ADATA  = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  localparam logic [7:0]  RESP_BIT  = 8'h80;
  localparam logic [7:0]  PTR_BITS  = 8'hC0;
  localparam logic [15:0] LEN_A     = 16'd4;
  localparam logic [15:0] LEN_AAAA  = 16'd16;
  localparam logic [3:0]  HDR_LEN   = 4'd12;
  localparam logic [3:0]  QTAIL_LEN = 4'd4;

  logic [2:0]  phase, phase_next;
  logic [3:0]  idx, idx_next;
  logic [15:0] q_left, q_left_next;
  logic [15:0] a_left, a_left_next;
  logic [7:0]  lbl_left, lbl_left_next;
  logic [15:0] rdl, rdl_next;
  logic [47:0] rhb, rhb_next;
  logic [63:0] ash_up, ash_up_next;
  logic [63:0] ash_lo, ash_lo_next;

  always_comb begin
    logic [7:0]  b;
    logic        enter_ans;
    logic [15:0] ans_cnt;
    logic [1:0]  emit;
    logic [1:0]  rec_kind;
    logic [63:0] cap_up;
    logic [63:0] cap_lo;

    b             = reply.reply_byte;
    enter_ans     = 1'b0;
    ans_cnt       = a_left;
    emit          = REC_NONE;
    rec_kind      = REC_NONE;
    cap_up        = '0;
    cap_lo        = '0;
    phase_next    = phase;
    idx_next      = idx;
    q_left_next   = q_left;
    a_left_next   = a_left;
    lbl_left_next = lbl_left;
    rdl_next      = rdl;
    rhb_next      = rhb;
    ash_up_next   = ash_up;
    ash_lo_next   = ash_lo;

    unique case (phase)
      PH_HEADER: begin
        if (idx == 4'd2 && (b & RESP_BIT) == 8'h00) begin
          phase_next = PH_ERROR;
        end else begin
          if (idx == 4'd4 || idx == 4'd5) q_left_next = {q_left[7:0], b};
          if (idx == 4'd6 || idx == 4'd7) a_left_next = {a_left[7:0], b};
          idx_next = idx + 4'd1;
          if (idx_next == HDR_LEN) begin
            if (q_left_next != 16'd0) begin
              phase_next    = PH_QLABEL;
              lbl_left_next = 8'd0;
            end else begin
              enter_ans = 1'b1;
              ans_cnt   = a_left_next;
            end
          end
        end
      end
      PH_QLABEL: begin
        if (lbl_left != 8'd0) begin
          lbl_left_next = lbl_left - 8'd1;
        end else if (b == 8'd0) begin
          phase_next = PH_QTAIL;
          idx_next   = QTAIL_LEN;
        end else begin
          lbl_left_next = b;
        end
      end
      PH_QTAIL: begin
        idx_next = idx - 4'd1;
        if (idx_next == 4'd0) begin
          q_left_next = q_left - 16'd1;
          if (q_left_next != 16'd0) begin
            phase_next    = PH_QLABEL;
            lbl_left_next = 8'd0;
          end else begin
            enter_ans = 1'b1;
          end
        end
      end
      PH_AHDR: begin
        if (idx == 4'd0 && (b & PTR_BITS) != PTR_BITS) begin
          phase_next = PH_ERROR;
        end else begin
          if (idx < 4'd6) rhb_next = {rhb[39:0], b};
          if (idx == 4'd10 || idx == 4'd11) rdl_next = {rdl[7:0], b};
          idx_next = idx + 4'd1;
          if (idx_next == HDR_LEN) begin
            if (rhb[15:0] == CLASS_IN && rhb[31:16] == TYPE_A && rdl_next == LEN_A)
              rec_kind = REC_V4;
            else if (rhb[15:0] == CLASS_IN && rhb[31:16] == TYPE_AAAA
                     && rdl_next == LEN_AAAA)
              rec_kind = REC_V6;
            rhb_next = {46'd0, rec_kind};
            idx_next = 4'd0;
            if (rdl_next == 16'd0) begin
              // empty record: done at once, nothing to report
              a_left_next = a_left - 16'd1;
              enter_ans   = 1'b1;
              ans_cnt     = a_left_next;
            end else begin
              phase_next = PH_ADATA;
            end
          end
        end
      end
      PH_ADATA: begin
        ash_up_next = {ash_up[55:0], ash_lo[63:56]};
        ash_lo_next = {ash_lo[55:0], b};
        rdl_next    = rdl - 16'd1;
        if (rdl_next == 16'd0) begin
          cap_up      = ash_up_next;
          cap_lo      = ash_lo_next;
          emit        = rhb[1:0];
          a_left_next = a_left - 16'd1;
          enter_ans   = 1'b1;
          ans_cnt     = a_left_next;
        end
      end
      PH_TRAIL: begin
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase

    if (enter_ans) begin
      if (ans_cnt != 16'd0) begin
        phase_next  = PH_AHDR;
        idx_next    = 4'd0;
        rhb_next    = '0;
        ash_up_next = '0;
        ash_lo_next = '0;
      end else begin
        phase_next = PH_TRAIL;
      end
    end

    evt.has_addr   = (emit == REC_V4) || (emit == REC_V6);
    evt.addr_v6    = (emit == REC_V6);
    evt.addr_upper = (emit == REC_V6) ? cap_up : 64'd0;
    evt.addr_lower = (emit == REC_V6) ? cap_lo : {32'd0, cap_lo[31:0]};
    evt.has_end    = reply.final_byte;
    evt.end_err    = (phase_next != PH_TRAIL);
    push           = accept && (evt.has_addr || reply.final_byte);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && reply.final_byte)) begin
      phase    <= PH_HEADER;
      idx      <= '0;
      q_left   <= '0;
      a_left   <= '0;
      lbl_left <= '0;
      rdl      <= '0;
      rhb      <= '0;
      ash_up   <= '0;
      ash_lo   <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      idx      <= idx_next;
      q_left   <= q_left_next;
      a_left   <= a_left_next;
      lbl_left <= lbl_left_next;
      rdl      <= rdl_next;
      rhb      <= rhb_next;
      ash_up   <= ash_up_next;
      ash_lo   <= ash_lo_next;
    end
  end

endmodule

@@ sv/dra_queue.sv @@
// small register queue of classified requests between parser and output side
module dra_queue
  import dra_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  dra_event_t push_evt,
  input  logic       pop,
  output logic       head_valid,
  output dra_event_t head,
  output logic       full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dra_event_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign full       = (count == CNT_FULL);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ sv/dra_back.sv @@
// output side: turns queued requests into address and status results
module dra_back
  import dra_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  dra_event_t   head,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  logic addr_sent;
  logic load;
  logic send_addr;

  assign load      = !result_valid || !result_stall;
  assign send_addr = head.has_addr && !addr_sent;
  // a request with both an address and a status stays until its status has been sent as well
  assign pop       = load && head_valid && !(send_addr && head.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      addr_sent    <= 1'b0;
    end else if (load) begin
      result_valid <= head_valid;
      if (head_valid) addr_sent <= send_addr && head.has_end;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (send_addr) begin
        result.result_kind   <= head.addr_v6 ? KIND_IPV6 : KIND_IPV4;
        result.address_upper <= head.addr_upper;
        result.address_lower <= head.addr_lower;
        result.run_end       <= 1'b0;
      end else begin
        result.result_kind   <= head.end_err ? KIND_END_ERR : KIND_END_OK;
        result.address_upper <= 64'd0;
        result.address_lower <= 64'd0;
        result.run_end       <= 1'b1;
      end
    end
  end

endmodule

@@ sv/dns_reply_address_extractor_unit.sv @@
// top level of the dns reply address extractor
//
//   channel   valid          stall          payload
//   reply     reply_valid    reply_stall    reply  (reply_item_t)
//   result    result_valid   result_stall   result (result_item_t)
//
// one reply byte is taken per cycle while reply_stall is low; the parser updates its counters in that cycle
// a byte giving results yields an address result, a status result, or both with the address first
// reply_stall rises only when the QUEUE_DEPTH-entry request queue is full
// each result passes through a queue entry and then the result register, from which it leaves
// rst is synchronous and clears parser, queue and output valid
module dns_reply_address_extractor_unit
  import dra_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         reply_valid,
  output logic         reply_stall,
  input  reply_item_t  reply,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  logic       accept;
  logic       push;
  dra_event_t push_evt;
  logic       pop;
  logic       head_valid;
  dra_event_t head;
  logic       full;

  assign reply_stall = full;
  assign accept      = reply_valid && !full;

  dra_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .reply  (reply),
    .push   (push),
    .evt    (push_evt)
  );

  dra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_evt   (push_evt),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (full)
  );

  dra_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ sv/dra_checker.sv @@
// port-level checks for the dns reply address extractor, bound to the top level
module dra_checker
  import dra_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         reply_valid,
  input logic         reply_stall,
  input reply_item_t  reply,
  input logic         result_valid,
  input logic         result_stall,
  input result_item_t result
);

  logic [7:0] ends_open;
  logic       fin_in;
  logic       end_out;

  assign fin_in  = reply_valid && !reply_stall && reply.final_byte;
  assign end_out = result_valid && !result_stall && result.run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ends_open <= '0;
    end else if (fin_in && !end_out) begin
      ends_open <= ends_open + 8'd1;
    end else if (end_out && !fin_in) begin
      ends_open <= ends_open - 8'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_end_has_reply: assert property (@(posedge clk) disable iff (rst)
    end_out |-> ends_open != 8'd0)
    else $error("status result without a finished reply");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_ipv4_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == KIND_IPV4 |->
      result.address_upper == 64'd0 && result.address_lower[63:32] == 32'd0
      && !result.run_end)
    else $error("malformed ipv4 result");

endmodule

bind dns_reply_address_extractor_unit dra_checker u_dra_checker (
  .clk          (clk),
  .rst          (rst),
  .reply_valid  (reply_valid),
  .reply_stall  (reply_stall),
  .reply        (reply),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
